[sv/pfba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_pkg: shared types and constants for the page frame bitmap allocator
// Payload structs, request kinds, register indexes and byte helpers.
// ----------------------------------------------------------------------------
package pfba_pkg;

    localparam int FRAME_COUNT = 1024;
    localparam int BYTE_BITS   = 8;
    localparam int BIT_W       = $clog2(BYTE_BITS);
    localparam int MAP_ROWS    = FRAME_COUNT / BYTE_BITS;
    localparam int ROW_W       = $clog2(MAP_ROWS);
    localparam int FRAME_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int CFG_IDX_W   = 1;

    localparam logic [COUNT_W-1:0]   FRAME_TOTAL = COUNT_W'(FRAME_COUNT);
    localparam logic [BYTE_BITS-1:0] BYTE_FULL   = 8'hFF;
    localparam logic [ROW_W-1:0]     ROW_LAST    = ROW_W'(MAP_ROWS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_INSTALLED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = 1'b1;

    typedef enum logic [1:0] {
        KIND_INIT    = 2'd0,
        KIND_ALLOC   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_COUNT   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [FRAME_W-1:0] frame_index;
    } req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] granted_frame;
        logic               status;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
    } rsp_t;

    function automatic logic [COUNT_W-1:0] clamp_frames(input logic [COUNT_W-1:0] v);
        return (v > FRAME_TOTAL) ? FRAME_TOTAL : v;
    endfunction

    // position of the lowest clear bit, only meaningful when one exists
    function automatic logic [BIT_W-1:0] first_zero(input logic [BYTE_BITS-1:0] b);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = BYTE_BITS - 1; i >= 0; i--)
        begin
            if (!b[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // used bits of one bitmap byte right after initialize
    function automatic logic [BYTE_BITS-1:0] init_byte(
        input logic [ROW_W-1:0]   row,
        input logic [COUNT_W-1:0] live,
        input logic [COUNT_W-1:0] rsv
    );
        logic [COUNT_W-1:0]   base;
        logic [COUNT_W-1:0]   f;
        logic [BYTE_BITS-1:0] b;
        base = COUNT_W'({row, BIT_W'(0)});
        b    = '0;
        for (int i = 0; i < BYTE_BITS; i++)
        begin
            f    = base + COUNT_W'(i);
            b[i] = (f >= live) || (f < rsv);
        end
        return b;
    endfunction

endpackage

[sv/pfba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_ram: generic single write port, single read port RAM
// Synchronous write, registered read (old data on same-address collision).
// ----------------------------------------------------------------------------
module pfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/page_frame_bitmap_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_top: first-fit page frame allocator
// Used/free bitmap in a byte-wide RAM, walked one byte per cycle by a sequencer.
// ----------------------------------------------------------------------------
// count goes straight to done, release reads then checks its row, initialize writes
// every row and allocate scans rows from the first; the bitmap RAM walks one byte
// per cycle, so one transaction is in flight and the next is taken when the
// sequencer is back in idle. one finished result may wait in the output register.
// reset: per-row valid flops clear, so the whole bitmap reads as used at once;
// no clearing pass, config writes are always taken.
module page_frame_bitmap_allocator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  pfba_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output pfba_pkg::rsp_t                      rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfba_pkg::COUNT_W-1:0]        cfg_data
);

    import pfba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_REL_RD,
        S_REL_CHK,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   installed_reg, installed_next;
    logic [COUNT_W-1:0]   reserved_reg, reserved_next;
    logic [COUNT_W-1:0]   live_reg, live_next;
    logic [COUNT_W-1:0]   rsv_reg, rsv_next;
    logic [COUNT_W-1:0]   used_reg, used_next;
    logic [MAP_ROWS-1:0]  row_valid_reg, row_valid_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ROW_W-1:0]     chk_row_reg, chk_row_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [FRAME_W-1:0]   idx_reg, idx_next;
    logic                 rowv_reg;
    rsp_t                 res_reg, res_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 ram_we;
    logic [ROW_W-1:0]     ram_waddr;
    logic [BYTE_BITS-1:0] ram_wdata;
    logic [ROW_W-1:0]     ram_raddr;
    logic [BYTE_BITS-1:0] ram_rdata;
    logic [BYTE_BITS-1:0] byte_eff;
    logic [BIT_W-1:0]     free_bit;
    logic [BIT_W-1:0]     rel_bit;

    pfba_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (MAP_ROWS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = (state_reg == S_SCAN) ? row_reg : idx_reg[FRAME_W-1 -: ROW_W];
    // a row never written since reset reads as all used
    assign byte_eff  = rowv_reg ? ram_rdata : BYTE_FULL;
    assign free_bit  = first_zero(byte_eff);
    assign rel_bit   = idx_reg[BIT_W-1:0];

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        installed_next = installed_reg;
        reserved_next  = reserved_reg;
        live_next      = live_reg;
        rsv_next       = rsv_reg;
        used_next      = used_reg;
        row_valid_next = row_valid_reg;
        row_next       = row_reg;
        chk_row_next   = chk_row_reg;
        chk_vld_next   = chk_vld_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = row_reg;
        ram_wdata      = BYTE_FULL;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_INSTALLED: installed_next = cfg_data;
                CFG_RESERVED:  reserved_next  = cfg_data;
            endcase
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    idx_next = req.frame_index;
                    res_next = '0;
                    unique case (req.kind)
                        KIND_INIT:
                        begin
                            live_next  = clamp_frames(installed_reg);
                            rsv_next   = clamp_frames(reserved_reg);
                            row_next   = '0;
                            state_next = S_INIT;
                        end
                        KIND_ALLOC:
                        begin
                            row_next     = '0;
                            chk_vld_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                        KIND_RELEASE:
                        begin
                            if ({1'b0, req.frame_index} < live_reg)
                            begin
                                state_next = S_REL_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        KIND_COUNT:
                        begin
                            res_next.used_count = used_reg;
                            res_next.free_count = live_reg - used_reg;
                            state_next          = S_DONE;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                ram_we                  = 1'b1;
                ram_waddr               = row_reg;
                ram_wdata               = init_byte(row_reg, live_reg, rsv_reg);
                row_valid_next[row_reg] = 1'b1;
                row_next                = row_reg + ROW_W'(1);
                if (row_reg == ROW_LAST)
                begin
                    // used frames below the installed count are just the reserved ones
                    used_next  = (rsv_reg < live_reg) ? rsv_reg : live_reg;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                // read of row_reg in flight while the byte of chk_row_reg is checked
                if (chk_vld_reg && (byte_eff != BYTE_FULL))
                begin
                    ram_we                      = 1'b1;
                    ram_waddr                   = chk_row_reg;
                    ram_wdata                   = byte_eff | (BYTE_BITS'(1) << free_bit);
                    row_valid_next[chk_row_reg] = 1'b1;
                    used_next                   = used_reg + COUNT_W'(1);
                    res_next.granted_frame      = {chk_row_reg, free_bit};
                    state_next                  = S_DONE;
                end
                else if (chk_vld_reg && (chk_row_reg == ROW_LAST))
                begin
                    res_next.status = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    chk_vld_next = 1'b1;
                    chk_row_next = row_reg;
                    row_next     = row_reg + ROW_W'(1);
                end
            end
            S_REL_RD:
            begin
                state_next = S_REL_CHK;
            end
            S_REL_CHK:
            begin
                if (byte_eff[rel_bit])
                begin
                    ram_we                                = 1'b1;
                    ram_waddr                             = idx_reg[FRAME_W-1 -: ROW_W];
                    ram_wdata                             = byte_eff & ~(BYTE_BITS'(1) << rel_bit);
                    row_valid_next[idx_reg[FRAME_W-1 -: ROW_W]] = 1'b1;
                    used_next                             = used_reg - COUNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            installed_reg <= FRAME_TOTAL;
            reserved_reg  <= COUNT_W'(1);
            live_reg      <= FRAME_TOTAL;
            rsv_reg       <= '0;
            used_reg      <= FRAME_TOTAL;
            row_valid_reg <= '0;
            row_reg       <= '0;
            chk_row_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            idx_reg       <= '0;
            rowv_reg      <= 1'b0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            installed_reg <= installed_next;
            reserved_reg  <= reserved_next;
            live_reg      <= live_next;
            rsv_reg       <= rsv_next;
            used_reg      <= used_next;
            row_valid_reg <= row_valid_next;
            row_reg       <= row_next;
            chk_row_reg   <= chk_row_next;
            chk_vld_reg   <= chk_vld_next;
            idx_reg       <= idx_next;
            rowv_reg      <= row_valid_reg[ram_raddr];
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[sv/pfba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfba_checker: port-level assertions for the page frame bitmap allocator
// Watches the request, response and config ports; bound to the top level.
// ----------------------------------------------------------------------------
module pfba_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input pfba_pkg::rsp_t                 rsp,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    import pfba_pkg::*;

    logic [COUNT_W:0] count_sum;
    assign count_sum = {1'b0, rsp.used_count} + {1'b0, rsp.free_count};

    // a held response transaction keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // sequencer is busy right after taking a request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

    // full status carries no frame and no counts
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |->
            rsp.granted_frame == '0 && rsp.used_count == '0 && rsp.free_count == '0)
        else $error("full status with nonzero payload");

    // used plus free never exceeds the frame total
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count_sum <= (COUNT_W+1)'(FRAME_COUNT))
        else $error("used plus free out of range");

    // config port is never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind page_frame_bitmap_allocator_top pfba_checker u_pfba_checker (.*);
